// ----- src/gfpq_pkg.sv -----
// ----------------------------------------------------------------------------
// gfpq_pkg
// Shared types for the group-filtered priority queue: item structs, the
// slot record held in the slot memory and the sequencer state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package gfpq_pkg;

  // Fixed field widths
  localparam int unsigned GroupW = 3;
  localparam int unsigned PrioW  = 2;
  localparam int unsigned OccW   = 5;
  localparam int unsigned LimitW = 5;

  // Reset value of the queue limit register
  localparam logic [LimitW-1:0] LimitReset = 5'd16;

  // Item kind codes
  localparam logic KindInsert = 1'b0;
  localparam logic KindTake   = 1'b1;

  // Input item
  typedef struct packed {
    logic              kind;
    logic [GroupW-1:0] group;
    logic [PrioW-1:0]  priority_req;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic              accepted;
    logic              found;
    logic [GroupW-1:0] taken_group;
    logic [PrioW-1:0]  taken_priority;
    logic [OccW-1:0]   occupancy;
  } out_item_t;

  // One stored request
  typedef struct packed {
    logic [GroupW-1:0] group;
    logic [PrioW-1:0]  prio;
  } slot_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_PICK,
    ST_SHIFT,
    ST_SHIFT_LAST
  } state_t;

endpackage : gfpq_pkg

`default_nettype wire

// ----- src/gfpq_slot_ram.sv -----
// ----------------------------------------------------------------------------
// gfpq_slot_ram
// Single-write, single-read slot memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gfpq_slot_ram
  import gfpq_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire slot_t         wdata,
  input  wire logic [AW-1:0] raddr,
  output slot_t              rdata
);

  slot_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule : gfpq_slot_ram

`default_nettype wire

// ----- src/group_filtered_priority_queue_core.sv -----
// ----------------------------------------------------------------------------
// group_filtered_priority_queue_core
// Bounded queue of requests tagged with a group and a priority; a take
// removes the oldest request of highest priority within one group.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result appears on
// result for exactly one cycle, marked by done, and must be taken then. An
// insert finishes at the accepting edge (busy stays low) and its result shows
// on the next cycle. A take on an empty queue does the same. Any other take
// walks the slot memory: it stays busy to scan every slot for the best
// match, then to pack the younger requests down by one when the request
// removed was not the tail. The slot memory has a single read port, and
// both the scan and the pack read one slot a cycle. done is high in the
// first cycle that busy is low again. queue_limit is written through
// cfg_we / cfg_wdata; the user must write it only while idle, as the block
// itself does not enforce this. Limits above DEPTH act as DEPTH and a
// limit of zero rejects every insert.
// ----------------------------------------------------------------------------
`default_nettype none

module group_filtered_priority_queue_core
  import gfpq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire in_item_t          request,
  output logic                   done,
  output out_item_t              result,
  input  wire logic              cfg_we,
  input  wire logic [LimitW-1:0] cfg_wdata
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = (CW > LimitW) ? CW : LimitW;

  // Registers
  state_t            state, state_next;
  logic [CW-1:0]     count;
  logic [LimitW-1:0] queue_limit;
  in_item_t          req_q;
  logic [AW-1:0]     ptr;
  logic [AW-1:0]     best_idx;
  logic [PrioW-1:0]  best_pri;
  logic              best_found;
  logic              rd_pending;
  logic [AW-1:0]     rd_idx;

  // Combinational
  logic              accept;
  logic              room;
  logic [AW-1:0]     last_idx;
  logic [LW-1:0]     lim_eff;
  logic              scan_hit;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  slot_t             mem_wdata;
  logic [AW-1:0]     mem_raddr;
  slot_t             rd_data;

  // Slot memory, packed in arrival order (slot 0 oldest)
  gfpq_slot_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  // Effective limit and room check
  always_comb begin
    lim_eff  = (LW'(queue_limit) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(queue_limit);
    room     = LW'(count) < lim_eff;
    last_idx = AW'(count - CW'(1));
    accept   = start && (state == ST_IDLE);
  end

  // A returned slot beats the current best for the asking group
  always_comb begin
    scan_hit = rd_pending && (rd_data.group == req_q.group) &&
               (!best_found || (rd_data.prio > best_pri));
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (request.kind == KindTake) && (count != '0)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (ptr == last_idx) begin
          state_next = ST_SCAN_LAST;
        end
      end
      ST_SCAN_LAST: begin
        state_next = ST_PICK;
      end
      ST_PICK: begin
        if (!best_found || (best_idx == last_idx)) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (ptr == last_idx) begin
          state_next = ST_SHIFT_LAST;
        end
      end
      ST_SHIFT_LAST: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Memory control and busy
  always_comb begin
    busy      = (state != ST_IDLE);
    mem_raddr = ptr;
    mem_we    = 1'b0;
    mem_waddr = rd_idx - AW'(1);
    mem_wdata = rd_data;
    unique case (state) inside
      ST_IDLE: begin
        // append at the tail
        mem_we          = accept && (request.kind == KindInsert) && room;
        mem_waddr       = AW'(count);
        mem_wdata.group = request.group;
        mem_wdata.prio  = request.priority_req;
      end
      ST_SHIFT, ST_SHIFT_LAST: begin
        // move the slot just read down by one
        mem_we = rd_pending;
      end
      ST_SCAN, ST_SCAN_LAST, ST_PICK: begin
        mem_we = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      queue_limit <= LimitReset;
    end else if (cfg_we) begin
      queue_limit <= cfg_wdata;
    end
  end

  // Read tracking: data for a read issued now returns next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= (state == ST_SCAN) || (state == ST_SHIFT);
    end
    rd_idx <= ptr;
  end

  // Sequencer datapath, count and result
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            req_q      <= request;
            ptr        <= '0;
            best_found <= 1'b0;
            if (request.kind == KindInsert) begin
              done                  <= 1'b1;
              result.accepted       <= room;
              result.found          <= 1'b0;
              result.taken_group    <= '0;
              result.taken_priority <= '0;
              if (room) begin
                count            <= count + CW'(1);
                result.occupancy <= OccW'(count + CW'(1));
              end else begin
                result.occupancy <= OccW'(count);
              end
            end else if (count == '0) begin
              done                  <= 1'b1;
              result.accepted       <= 1'b0;
              result.found          <= 1'b0;
              result.taken_group    <= '0;
              result.taken_priority <= '0;
              result.occupancy      <= OccW'(count);
            end
          end
        end
        ST_SCAN: begin
          ptr <= ptr + AW'(1);
          if (scan_hit) begin
            best_found <= 1'b1;
            best_idx   <= rd_idx;
            best_pri   <= rd_data.prio;
          end
        end
        ST_SCAN_LAST: begin
          if (scan_hit) begin
            best_found <= 1'b1;
            best_idx   <= rd_idx;
            best_pri   <= rd_data.prio;
          end
        end
        ST_PICK: begin
          ptr <= best_idx + AW'(1);
          result.accepted <= 1'b0;
          if (!best_found) begin
            done                  <= 1'b1;
            result.found          <= 1'b0;
            result.taken_group    <= '0;
            result.taken_priority <= '0;
            result.occupancy      <= OccW'(count);
          end else if (best_idx == last_idx) begin
            // removed the tail: nothing to pack
            done                  <= 1'b1;
            count                 <= count - CW'(1);
            result.found          <= 1'b1;
            result.taken_group    <= req_q.group;
            result.taken_priority <= best_pri;
            result.occupancy      <= OccW'(count - CW'(1));
          end
        end
        ST_SHIFT: begin
          ptr <= ptr + AW'(1);
        end
        ST_SHIFT_LAST: begin
          done                  <= 1'b1;
          count                 <= count - CW'(1);
          result.accepted       <= 1'b0;
          result.found          <= 1'b1;
          result.taken_group    <= req_q.group;
          result.taken_priority <= best_pri;
          result.occupancy      <= OccW'(count - CW'(1));
        end
        default: begin
          done <= 1'b0;
        end
      endcase
    end
  end

endmodule : group_filtered_priority_queue_core

`default_nettype wire

// ----- verif/group_filtered_priority_queue_core_test.sv -----
// ----------------------------------------------------------------------------
// group_filtered_priority_queue_core_test
// Self-checking bench for the group-filtered priority queue. Directed items
// cover empty and unmatched takes, priority and arrival ordering, a zero
// priority, and a limit of zero and of one. Random traffic follows under
// several queue limits, some above depth. A shadow queue in the bench
// predicts every result, and a checker compares each strobed result with
// the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module group_filtered_priority_queue_core_test;
  import gfpq_pkg::*;

  localparam int unsigned SlotCount  = 16;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned TailCycles = 40;
  localparam int unsigned MaxPrinted = 40;

  // DUT signals
  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             start     = 1'b0;
  logic             busy;
  in_item_t         request   = '0;
  logic             done;
  out_item_t        result;
  logic             cfg_we    = 1'b0;
  logic [LimitW-1:0] cfg_wdata = '0;

  // Shadow queue contents, packed oldest first
  logic [GroupW-1:0] held_group [SlotCount];
  logic [PrioW-1:0]  held_prio  [SlotCount];
  int unsigned       held_count = 0;
  logic [LimitW-1:0] limit_shadow = LimitReset;

  out_item_t   expected_results [$];
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;

  group_filtered_priority_queue_core #(.DEPTH(SlotCount)) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Clock
  always #6 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report(input string msg);
    if (mismatches < MaxPrinted) $display("ERROR @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Shadow queue step: returns the result one item should produce
  function automatic out_item_t apply_request(input in_item_t item);
    out_item_t         r;
    int unsigned       lim;
    int                best;
    logic [PrioW-1:0]  best_p;
    r      = '0;
    lim    = (limit_shadow < SlotCount) ? limit_shadow : SlotCount;
    best   = -1;
    best_p = '0;
    if (item.kind == KindInsert) begin
      if (held_count < lim) begin
        held_group[held_count] = item.group;
        held_prio[held_count]  = item.priority_req;
        held_count++;
        r.accepted = 1'b1;
      end
    end else begin
      // strict compare keeps the oldest among equal priorities
      for (int i = 0; i < int'(held_count); i++) begin
        if (held_group[i] == item.group && (best < 0 || held_prio[i] > best_p)) begin
          best   = i;
          best_p = held_prio[i];
        end
      end
      if (best >= 0) begin
        r.found          = 1'b1;
        r.taken_group    = held_group[best];
        r.taken_priority = held_prio[best];
        for (int i = best; i < int'(held_count) - 1; i++) begin
          held_group[i] = held_group[i+1];
          held_prio[i]  = held_prio[i+1];
        end
        held_count--;
      end
    end
    r.occupancy = held_count[OccW-1:0];
    return r;
  endfunction

  // Result checker
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result %p", result));
      end else begin
        exp_r = expected_results.pop_front();
        if (result.accepted !== exp_r.accepted)
          report($sformatf("accepted got %b exp %b", result.accepted, exp_r.accepted));
        if (result.found !== exp_r.found)
          report($sformatf("found got %b exp %b", result.found, exp_r.found));
        if (result.taken_group !== exp_r.taken_group)
          report($sformatf("taken_group got %0d exp %0d",
                           result.taken_group, exp_r.taken_group));
        if (result.taken_priority !== exp_r.taken_priority)
          report($sformatf("taken_priority got %0d exp %0d",
                           result.taken_priority, exp_r.taken_priority));
        if (result.occupancy !== exp_r.occupancy)
          report($sformatf("occupancy got %0d exp %0d",
                           result.occupancy, exp_r.occupancy));
      end
    end
  end

  // Present one item and hold it until the block takes it
  task automatic send_item(input in_item_t item);
    start   <= 1'b1;
    request <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results = {expected_results, apply_request(item)};
  endtask

  task automatic idle_for(input int unsigned n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_insert(input logic [GroupW-1:0] g, input logic [PrioW-1:0] p);
    in_item_t item;
    item.kind         = KindInsert;
    item.group        = g;
    item.priority_req = p;
    send_item(item);
    idle_for(pick_gap());
  endtask

  task automatic send_take(input logic [GroupW-1:0] g, input logic [PrioW-1:0] p);
    in_item_t item;
    item.kind         = KindTake;
    item.group        = g;
    item.priority_req = p;
    send_item(item);
    idle_for(pick_gap());
  endtask

  // Hold off until every expected result has arrived
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_limit(input logic [LimitW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_shadow = v;
  endtask

  // Take on an empty queue
  task automatic test_take_on_empty();
    send_take(3'd0, 2'd0);
    send_take(3'd7, 2'd3);
    drain();
  endtask

  // Highest priority first, oldest first among equals, zero priority last
  task automatic test_priority_and_arrival_order();
    send_insert(3'd7, 2'd1);
    send_insert(3'd7, 2'd3);
    send_insert(3'd7, 2'd3);
    send_insert(3'd0, 2'd2);
    send_insert(3'd7, 2'd0);
    send_insert(3'd3, 2'd1);
    send_take(3'd7, 2'd0);
    send_take(3'd7, 2'd1);
    send_take(3'd7, 2'd2);
    send_take(3'd7, 2'd3);
    send_take(3'd7, 2'd0);   // no match left in group 7
    send_take(3'd0, 2'd3);
    send_take(3'd3, 2'd1);
    drain();
  endtask

  // Limit of zero rejects every insert
  task automatic test_limit_zero();
    write_limit(5'd0);
    send_insert(3'd1, 2'd2);
    send_take(3'd1, 2'd2);
    drain();
  endtask

  // Limit of one: second insert is rejected
  task automatic test_limit_one();
    write_limit(5'd1);
    send_insert(3'd5, 2'd3);
    send_insert(3'd2, 2'd1);
    send_take(3'd5, 2'd0);
    drain();
  endtask

  // One random phase under a given limit
  task automatic run_random_phase(input logic [LimitW-1:0] lim,
                                  input int unsigned n_items,
                                  input int unsigned insert_pct,
                                  input int unsigned group_span,
                                  input bit no_idle);
    in_item_t item;
    drain();
    write_limit(lim);
    for (int unsigned k = 0; k < n_items; k++) begin
      item.group = GroupW'($urandom_range(0, group_span));
      if ($urandom_range(0, 99) < insert_pct) begin
        item.kind         = KindInsert;
        item.priority_req = ($urandom_range(0, 9) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
      end else begin
        item.kind         = KindTake;
        item.priority_req = PrioW'($urandom_range(0, 3));
      end
      send_item(item);
      if (!no_idle) idle_for(pick_gap());
      if ($urandom_range(0, 59) == 0) drain();
    end
  endtask

  // Random traffic under several limits, extremes included
  task automatic test_random_traffic();
    run_random_phase(5'd16, 160, 55, 7, 1'b0);
    run_random_phase(5'd31, 160, 60, 7, 1'b0);
    run_random_phase(5'd17, 140, 50, 1, 1'b0);
    run_random_phase(5'd3,  120, 50, 7, 1'b0);
    run_random_phase(5'd0,   40, 50, 7, 1'b0);
    run_random_phase(5'd8,  140, 45, 3, 1'b0);
    run_random_phase(5'($urandom_range(0, 31)), 140, 55, 7, 1'b0);
    run_random_phase(5'd16, 100, 50, 7, 1'b1);
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_take_on_empty();
    test_priority_and_arrival_order();
    test_limit_zero();
    test_limit_one();
    test_random_traffic();

    // Let any stray result show up
    repeat (TailCycles) @(posedge clk);
    if (expected_results.size() != 0)
      report($sformatf("%0d results never arrived", expected_results.size()));

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule : group_filtered_priority_queue_core_test

`default_nettype wire

// ----- sim.f -----
src/gfpq_pkg.sv
src/gfpq_slot_ram.sv
src/group_filtered_priority_queue_core.sv
verif/group_filtered_priority_queue_core_test.sv
